/* design/tscc_pkg.sv */
// shared constants, types and codes of the table search comparison counter
`timescale 1ns / 1ps

package tscc_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = 32;
    localparam int IW    = 10;
    localparam int OPW   = 2;
    localparam int SW    = 11;
    localparam int CW    = 11;

    typedef logic [AW-1:0] t_addr;
    typedef logic [AW:0]   t_ucnt;
    typedef logic [AW+1:0] t_sum;
    typedef logic [CW-1:0] t_cnt;
    typedef logic [SW-1:0] t_size;

    typedef enum logic [OPW-1:0] {
        OP_WRITE   = 2'd0,
        OP_BSEARCH = 2'd1,
        OP_LSEARCH = 2'd2
    } t_op;

endpackage

/* design/tscc_ifs.sv */
// valid/ready channels for input items and result items
`timescale 1ns / 1ps

interface tscc_in_if;
    logic                      valid;
    logic                      ready;
    logic [tscc_pkg::OPW-1:0]  op;
    logic [tscc_pkg::IW-1:0]   index;
    logic signed [tscc_pkg::VW-1:0] value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface tscc_out_if;
    logic                     valid;
    logic                     ready;
    logic [tscc_pkg::CW-1:0]  comparisons;
    logic                     found;

    modport source (output valid, output comparisons, output found, input ready);
    modport sink   (input valid, input comparisons, input found, output ready);
endinterface

/* design/tscc_ram.sv */
// generic single-port ram with registered read
`timescale 1ns / 1ps

module tscc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/table_search_comparison_counter.sv */
// top level: table memory and probe sequencer for binary and linear searches
//
// usage: input items arrive on i_item (op, index, value) with valid/ready.
// a write item (op 0) stores value at index; an index beyond
// the table is dropped. op 1 runs a binary search, op 2 a linear search of
// the first table_size entries for the key in value; op 3 is taken and
// dropped. each search gives one result item on o_result (comparisons,
// found). table_size is set through i_cfg_we / i_cfg_wdata, clipped to the
// table depth; the user must set it while idle, the block does not enforce it.
// throughput: one item at a time. a search makes one probe per cycle, one
// read of the single-port table memory each, up to DEPTH probes for a linear
// search and about log2(DEPTH) + 1 for a binary one. the next item is taken
// once the result has entered the output register. an empty table gives its
// result at the accepting edge if the output register is free.
// the result sits in an output register; the next item is accepted while it
// waits. a finished search whose result finds that register still full
// holds until the receiver takes it, and no item is accepted meanwhile.
// reset (synchronous, active low) clears table_size and the control state;
// the table contents are undefined until written.
`timescale 1ns / 1ps

module table_search_comparison_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tscc_pkg::SW-1:0]     i_cfg_wdata,
    tscc_in_if.sink                     i_item,
    tscc_out_if.source                  o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_HOLD
    } t_state;

    t_state                        r_state;
    tscc_pkg::t_size               r_size;
    logic signed [tscc_pkg::VW-1:0] r_key;
    logic                          r_bin;
    tscc_pkg::t_ucnt               r_lo;
    tscc_pkg::t_ucnt               r_end;
    tscc_pkg::t_addr               r_addr;
    tscc_pkg::t_cnt                r_cnt;
    tscc_pkg::t_cnt                r_cmp;
    logic                          r_found;
    logic                          r_ovalid;
    tscc_pkg::t_cnt                r_ocmp;
    logic                          r_ofound;

    logic                          w_acc;
    logic                          w_slot;
    logic                          w_query;
    logic                          w_load;
    tscc_pkg::t_ucnt               w_used;
    tscc_pkg::t_addr               w_start;
    logic                          w_we;
    tscc_pkg::t_addr               w_ram_addr;
    logic signed [tscc_pkg::VW-1:0] w_rdata;
    logic                          w_hit;
    logic                          w_gt;
    tscc_pkg::t_ucnt               n_lo;
    tscc_pkg::t_ucnt               n_end;
    logic                          n_cont;
    tscc_pkg::t_addr               n_next;

    function automatic tscc_pkg::t_addr f_mid(tscc_pkg::t_ucnt lo, tscc_pkg::t_ucnt hi_ex);
        tscc_pkg::t_sum s;
        s = tscc_pkg::t_sum'(lo) + tscc_pkg::t_sum'(hi_ex) - tscc_pkg::t_sum'(1);
        return tscc_pkg::t_addr'(s >> 1);
    endfunction

    tscc_ram #(
        .WIDTH (tscc_pkg::VW),
        .DEPTH (tscc_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_ram_addr),
        .i_wdata (i_item.value),
        .o_rdata (w_rdata)
    );

    assign i_item.ready         = (r_state == S_IDLE);
    assign o_result.valid       = r_ovalid;
    assign o_result.comparisons = r_ocmp;
    assign o_result.found       = r_ofound;

    assign w_acc   = i_item.valid && i_item.ready;
    assign w_slot  = !r_ovalid || o_result.ready;
    assign w_query = (i_item.op == tscc_pkg::OP_BSEARCH) ||
                     (i_item.op == tscc_pkg::OP_LSEARCH);
    assign w_used  = (32'(r_size) > 32'(tscc_pkg::DEPTH)) ?
                     tscc_pkg::t_ucnt'(tscc_pkg::DEPTH) : tscc_pkg::t_ucnt'(r_size);
    assign w_start = (i_item.op == tscc_pkg::OP_BSEARCH) ?
                     f_mid(tscc_pkg::t_ucnt'(0), w_used) : tscc_pkg::t_addr'(0);

    assign w_hit = (r_key == w_rdata);
    assign w_gt  = (r_key > w_rdata);

    // a result item enters the output register this cycle
    assign w_load = w_slot &&
                    (((r_state == S_IDLE) && w_acc && w_query && (w_used == '0)) ||
                     ((r_state == S_SEARCH) && !n_cont) ||
                     (r_state == S_HOLD));

    always_comb begin
        if (r_bin) begin
            n_lo  = w_gt ? tscc_pkg::t_ucnt'(r_addr) + tscc_pkg::t_ucnt'(1) : r_lo;
            n_end = w_gt ? r_end : tscc_pkg::t_ucnt'(r_addr);
        end else begin
            n_lo  = tscc_pkg::t_ucnt'(r_addr) + tscc_pkg::t_ucnt'(1);
            n_end = r_end;
        end
        n_cont = !w_hit && (n_lo < n_end);
        n_next = r_bin ? f_mid(n_lo, n_end) : tscc_pkg::t_addr'(n_lo);
    end

    always_comb begin
        w_we       = 1'b0;
        w_ram_addr = r_addr;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_item.op == tscc_pkg::OP_WRITE) begin
                        w_we       = (32'(i_item.index) < 32'(tscc_pkg::DEPTH));
                        w_ram_addr = tscc_pkg::t_addr'(i_item.index);
                    end else begin
                        w_ram_addr = w_start;
                    end
                end
            end
            S_SEARCH: begin
                w_ram_addr = n_next;
            end
            default: begin
                w_ram_addr = r_addr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (o_result.ready && !w_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc && w_query) begin
                        r_key  <= i_item.value;
                        r_bin  <= (i_item.op == tscc_pkg::OP_BSEARCH);
                        r_lo   <= '0;
                        r_end  <= w_used;
                        r_addr <= w_start;
                        r_cnt  <= tscc_pkg::t_cnt'(1);
                        if (w_used == '0) begin
                            // empty table: no probes
                            if (w_slot) begin
                                r_ovalid <= 1'b1;
                                r_ocmp   <= '0;
                                r_ofound <= 1'b0;
                            end else begin
                                r_cmp   <= '0;
                                r_found <= 1'b0;
                                r_state <= S_HOLD;
                            end
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (n_cont) begin
                        r_lo   <= n_lo;
                        r_end  <= n_end;
                        r_addr <= n_next;
                        r_cnt  <= r_cnt + tscc_pkg::t_cnt'(1);
                    end else if (w_slot) begin
                        r_ovalid <= 1'b1;
                        r_ocmp   <= r_cnt;
                        r_ofound <= w_hit;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cmp   <= r_cnt;
                        r_found <= w_hit;
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_slot) begin
                        r_ovalid <= 1'b1;
                        r_ocmp   <= r_cmp;
                        r_ofound <= r_found;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sim/tb_top.sv */
// testbench for table_search_comparison_counter: predicts search results and checks each one
`timescale 1ns / 1ps

module tb_top;
    import tscc_pkg::*;

    localparam logic [OPW-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000 * (DEPTH + 16) * 3;
    localparam int SIZE_MAX = (1 << SW) - 1;
    localparam logic signed [VW-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic signed [VW-1:0] KEY_MAX = 32'h7fff_ffff;

    typedef struct packed {
        t_cnt comparisons;
        logic found;
    } t_search_result;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    t_size cfg_wdata;

    tscc_in_if  item_ch();
    tscc_out_if result_ch();

    table_search_comparison_counter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    logic signed [VW-1:0] entry_mem [DEPTH];
    t_size                size_reg;
    t_search_result       expected_results [$];
    int                   error_count = 0;
    int                   cycle_count = 0;
    int                   hold_request = 0;
    bit                   steady_flow = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int used_entries();
        return (size_reg > DEPTH) ? DEPTH : int'(size_reg);
    endfunction

    function automatic t_search_result predict_binary_search(input logic signed [VW-1:0] key);
        t_search_result res;
        int lo, hi, mid, probes;
        res = '0;
        lo = 0;
        hi = used_entries() - 1;
        probes = 0;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            probes++;
            if (key == entry_mem[mid]) begin
                res.found = 1'b1;
                break;
            end
            if (key > entry_mem[mid]) lo = mid + 1;
            else hi = mid - 1;
        end
        res.comparisons = t_cnt'(probes);
        return res;
    endfunction

    function automatic t_search_result predict_linear_search(input logic signed [VW-1:0] key);
        t_search_result res;
        int probes;
        res = '0;
        probes = 0;
        for (int i = 0; i < used_entries(); i++) begin
            probes++;
            if (entry_mem[i] == key) begin
                res.found = 1'b1;
                break;
            end
        end
        res.comparisons = t_cnt'(probes);
        return res;
    endfunction

    // mostly keys that sit in the searched part of the table, or just beside an entry
    function automatic logic signed [VW-1:0] pick_key(input int n);
        int pick;
        logic signed [VW-1:0] k;
        pick = $urandom_range(0, 9);
        k = $urandom();
        if (n > 0 && pick < 5) k = entry_mem[$urandom_range(0, n - 1)];
        else if (n > 0 && pick < 7)
            k = entry_mem[$urandom_range(0, n - 1)] + ((pick == 5) ? 1 : -1);
        else if (pick == 8) k = KEY_MIN;
        else if (pick == 9) k = KEY_MAX;
        return k;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic send_item(input logic [OPW-1:0] op, input t_addr idx,
                             input logic signed [VW-1:0] val);
        if (!steady_flow && $urandom_range(99) < 27) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.op    <= op;
        item_ch.index <= idx;
        item_ch.value <= val;
        do @(posedge clk); while (!item_ch.ready);
        case (op)
            OP_WRITE:   entry_mem[idx] = val;
            OP_BSEARCH: expected_results.insert(expected_results.size(),
                                                predict_binary_search(val));
            OP_LSEARCH: expected_results.insert(expected_results.size(),
                                                predict_linear_search(val));
            default: ;
        endcase
    endtask

    task automatic send_query(input int n);
        send_item($urandom_range(0, 1) ? OP_BSEARCH : OP_LSEARCH, t_addr'($urandom()),
                  pick_key(n));
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_table_size(input int unsigned n);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= t_size'(n);
        @(posedge clk);
        cfg_we <= 1'b0;
        size_reg = t_size'(n);
    endtask

    task automatic load_ascending(input int n, input int max_step);
        longint v;
        v = longint'($signed($urandom()));
        if (v > 64'sd2147483647 - longint'(n) * max_step)
            v = 64'sd2147483647 - longint'(n) * max_step;
        for (int i = 0; i < n; i++) begin
            send_item(OP_WRITE, t_addr'(i), v[VW-1:0]);
            v += $urandom_range(0, max_step);
        end
    endtask

    task automatic load_scrambled(input int n);
        for (int i = 0; i < n; i++) send_item(OP_WRITE, t_addr'(i), $urandom());
    endtask

    task automatic test_empty_table();
        set_table_size(0);
        send_item(OP_BSEARCH, '0, '0);
        send_item(OP_LSEARCH, '1, KEY_MIN);
        send_item(OP_UNUSED, t_addr'(DEPTH - 1), KEY_MAX);
    endtask

    task automatic test_directed_small();
        logic signed [VW-1:0] ladder [8];
        ladder = '{KEY_MIN, -7, 0, 5, 9, 1000, 65536, KEY_MAX};
        for (int i = 0; i < 8; i++) send_item(OP_WRITE, t_addr'(i), ladder[i]);
        set_table_size(8);
        send_item(OP_BSEARCH, '0, KEY_MIN);
        send_item(OP_BSEARCH, '0, KEY_MAX);
        send_item(OP_BSEARCH, '0, 5);
        send_item(OP_BSEARCH, '0, 6);
        send_item(OP_LSEARCH, '0, KEY_MAX);
        send_item(OP_LSEARCH, '0, KEY_MIN);
        send_item(OP_LSEARCH, '0, 4);
        set_table_size(1);
        send_item(OP_BSEARCH, '0, KEY_MIN);
        send_item(OP_LSEARCH, '0, 0);
        set_table_size(2);
        send_item(OP_BSEARCH, '0, -7);
        // out of order table
        set_table_size(8);
        send_item(OP_WRITE, '0, KEY_MAX);
        send_item(OP_BSEARCH, '0, KEY_MAX);
        send_item(OP_LSEARCH, '0, KEY_MAX);
        send_item(OP_BSEARCH, '0, -7);
    endtask

    task automatic test_full_table();
        load_ascending(DEPTH, 4000000);
        send_item(OP_WRITE, '0, KEY_MIN);
        send_item(OP_WRITE, t_addr'(DEPTH - 1), KEY_MAX);
        set_table_size(DEPTH);
        send_item(OP_BSEARCH, '0, KEY_MAX);
        send_item(OP_BSEARCH, '0, KEY_MIN);
        send_item(OP_BSEARCH, '0, entry_mem[517]);
        send_item(OP_BSEARCH, '0, entry_mem[300] + 1);
        send_item(OP_LSEARCH, '0, KEY_MAX);
        send_item(OP_LSEARCH, '0, entry_mem[DEPTH - 2] + 1);
        // size beyond the table
        set_table_size(SIZE_MAX);
        send_item(OP_LSEARCH, '0, $urandom());
        send_item(OP_BSEARCH, '0, KEY_MAX);
        set_table_size(DEPTH - 1);
        send_item(OP_LSEARCH, '0, KEY_MAX);
        send_item(OP_BSEARCH, '0, KEY_MAX);
    endtask

    task automatic test_steady_stream();
        steady_flow = 1'b1;
        set_table_size(24);
        load_ascending(24, 8);
        repeat (40) send_query(24);
        wait_idle();
        steady_flow = 1'b0;
    endtask

    task automatic test_result_backpressure();
        set_table_size(16);
        load_ascending(16, 4);
        hold_request = 300;
        repeat (24) send_query(16);
        // sender waits for every result before going on
        wait_idle();
        repeat (8) send_query(16);
    endtask

    task automatic test_random_phases();
        int sent, sel, n, queries;
        sent = 0;
        while (sent < 400) begin
            sel = $urandom_range(0, 19);
            case (sel)
                0: set_table_size(0);
                1: set_table_size(DEPTH);
                2: set_table_size(SIZE_MAX);
                3: set_table_size($urandom_range(DEPTH + 1, SIZE_MAX));
                4: set_table_size($urandom_range(33, DEPTH - 1));
                default: set_table_size($urandom_range(1, 32));
            endcase
            n = used_entries();
            if (n <= 32) begin
                if ($urandom_range(0, 4) != 0) load_ascending(n, 8);
                else load_scrambled(n);
                sent += n;
                queries = $urandom_range(8, 20);
            end else begin
                queries = $urandom_range(2, 5);
            end
            repeat (queries) begin
                sel = $urandom_range(0, 19);
                if (sel == 0) begin
                    send_item(OP_UNUSED, t_addr'($urandom()), $urandom());
                end else if (sel == 1) begin
                    send_item(OP_WRITE, t_addr'($urandom()), $urandom());
                    sent++;
                end else begin
                    send_query(n);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (steady_flow) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= 27);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_search_result want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with no query pending: comparisons %0d found %0d",
                                          result_ch.comparisons, result_ch.found));
            end else begin
                want = expected_results.pop_front();
                if (result_ch.comparisons !== want.comparisons)
                    report_mismatch($sformatf("comparisons %0d, expected %0d",
                                              result_ch.comparisons, want.comparisons));
                if (result_ch.found !== want.found)
                    report_mismatch($sformatf("found %0d, expected %0d",
                                              result_ch.found, want.found));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        item_ch.valid = 1'b0;
        item_ch.op    = OP_WRITE;
        item_ch.index = '0;
        item_ch.value = '0;
        size_reg      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_directed_small();
        test_full_table();
        test_steady_stream();
        test_result_backpressure();
        test_random_phases();

        wait_idle();
        repeat (DEPTH + 8) @(posedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
